FILE: rtl/throttle_feedforward_interpolator_top_macros.svh
// Assertion shorthands for the top-level RTL file.
`ifndef THROTTLE_FEEDFORWARD_INTERPOLATOR_TOP_MACROS_SVH
`define THROTTLE_FEEDFORWARD_INTERPOLATOR_TOP_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TFI_ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define TFI_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/tfi_pkg.sv
package tfi_pkg;

   localparam int POS_W        = 16;
   localparam int DUTY_W       = 10;
   localparam int SUM_W        = POS_W + 1;
   localparam int DIFF_W       = POS_W + 1;
   localparam int QUOT_W       = DUTY_W + 1;
   localparam int PROD_W       = QUOT_W + DIFF_W;
   localparam int DIV_STEPS    = DUTY_W;
   localparam int DIV_CNT_W    = 4;
   localparam int NUM_SLOTS    = 4;
   localparam int SLOT_W       = 2;
   localparam int TABLE_POINTS = 4;
   localparam int LAST_POINT   = TABLE_POINTS - 1;
   localparam int CSR_IDX_W    = 3;
   localparam int CSR_DATA_W   = 16;

   // Register map: positions first, then duties
   localparam logic [CSR_IDX_W-1:0] REG_POS_BASE  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_DUTY_BASE = 3'd4;

   localparam logic signed [POS_W-1:0] POS_RESET [NUM_SLOTS] =
      '{16'sd10, 16'sd25, 16'sd40, 16'sd70};
   localparam logic [DUTY_W-1:0] DUTY_RESET [NUM_SLOTS] =
      '{10'd0, 10'd150, 10'd250, 10'd300};

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

FILE: rtl/tfi_divider.sv
// Restoring divider, one quotient bit per cycle, unsigned operands.
module tfi_divider (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic [tfi_pkg::DUTY_W-1:0]          dividend,
   input  logic [tfi_pkg::POS_W-1:0]           divisor,
   output logic [tfi_pkg::DUTY_W-1:0]          quotient,
   output tfi_pkg::div_status_type             status
);

   logic [tfi_pkg::DUTY_W-1:0]    quot_ff, quot_in;
   logic [tfi_pkg::POS_W-1:0]     rem_ff, rem_in;
   logic [tfi_pkg::POS_W-1:0]     div_ff, div_in;
   logic [tfi_pkg::DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                          busy_ff, busy_in;
   logic                          done_ff, done_in;
   logic [tfi_pkg::POS_W:0]       trial;
   logic [tfi_pkg::POS_W:0]       trial_diff;
   logic                          fits;

   assign trial      = {rem_ff, quot_ff[tfi_pkg::DUTY_W-1]};
   assign fits       = trial >= {1'b0, div_ff};
   assign trial_diff = trial - {1'b0, div_ff};

   always_comb begin
      quot_in = quot_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quot_in = dividend;
         rem_in  = '0;
         div_in  = divisor;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // shift in the next dividend bit, subtract when it fits
         quot_in = {quot_ff[tfi_pkg::DUTY_W-2:0], fits};
         rem_in  = fits ? trial_diff[tfi_pkg::POS_W-1:0] : trial[tfi_pkg::POS_W-1:0];
         cnt_in  = cnt_ff + 1'b1;
         if (cnt_ff == tfi_pkg::DIV_CNT_W'(tfi_pkg::DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      div_ff  <= div_in;
   end

   assign quotient    = quot_ff;
   assign status.busy = busy_ff;
   assign status.done = done_ff;

endmodule

FILE: rtl/throttle_feedforward_interpolator_top.sv
// From start to rsp_strobe: ST_AVG, ST_SEL when the average is clamped to an end point,
//   plus ST_PREP on a flat segment; plus ST_DIV, ST_MUL, ST_FIN when interpolating.
// Start is taken only in idle; busy stays high until the result is shown.
//   Interpolated points wait on the 10-step divider.
// The receiver cannot stall: rsp_strobe is high for exactly one cycle per word.
// Synchronous active-high reset idles the sequencer and loads the default spring table.
module throttle_feedforward_interpolator_top (
   input  logic                                  clock,
   input  logic                                  reset,
   // input word
   input  logic                                  start,
   output logic                                  busy,
   input  logic signed [tfi_pkg::POS_W-1:0]      req_sensor_a_position,
   input  logic signed [tfi_pkg::POS_W-1:0]      req_sensor_b_position,
   // result word
   output logic                                  rsp_strobe,
   output logic signed [tfi_pkg::POS_W-1:0]      rsp_feedforward_duty,
   // register writes
   input  logic                                  csr_write_enable,
   input  logic [tfi_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [tfi_pkg::CSR_DATA_W-1:0]        csr_write_data
);

   `include "throttle_feedforward_interpolator_top_macros.svh"

   // Sequencer states
   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_AVG  = 3'd1;
   localparam logic [2:0] ST_SEL  = 3'd2;
   localparam logic [2:0] ST_PREP = 3'd3;
   localparam logic [2:0] ST_DIV  = 3'd4;
   localparam logic [2:0] ST_MUL  = 3'd5;
   localparam logic [2:0] ST_FIN  = 3'd6;

   // Spring table
   logic signed [tfi_pkg::POS_W-1:0] pos_ff  [tfi_pkg::NUM_SLOTS];
   logic [tfi_pkg::DUTY_W-1:0]       duty_ff [tfi_pkg::NUM_SLOTS];

   logic [2:0]                        state_ff, state_in;
   logic signed [tfi_pkg::SUM_W-1:0]  sum_ff, sum_in;
   logic signed [tfi_pkg::POS_W-1:0]  p_ff, p_in;
   logic signed [tfi_pkg::POS_W-1:0]  lo_pos_ff, lo_pos_in;
   logic signed [tfi_pkg::POS_W-1:0]  hi_pos_ff, hi_pos_in;
   logic [tfi_pkg::DUTY_W-1:0]        lo_duty_ff, lo_duty_in;
   logic [tfi_pkg::DUTY_W-1:0]        hi_duty_ff, hi_duty_in;
   logic                              dd_neg_ff, dd_neg_in;
   logic signed [tfi_pkg::DIFF_W-1:0] dx_ff, dx_in;
   logic signed [tfi_pkg::QUOT_W-1:0] q_ff, q_in;
   logic [tfi_pkg::POS_W-1:0]         prod_ff, prod_in;
   logic                              rsp_strobe_ff, rsp_strobe_in;
   logic [tfi_pkg::POS_W-1:0]         rsp_duty_ff, rsp_duty_in;

   // Datapath helpers
   logic signed [tfi_pkg::SUM_W-1:0]  sum_adj;
   logic signed [tfi_pkg::QUOT_W-1:0] dd;
   logic [tfi_pkg::DUTY_W-1:0]        dd_mag;
   logic signed [tfi_pkg::DIFF_W-1:0] dp;
   logic signed [tfi_pkg::PROD_W-1:0] prod_full;
   logic signed [tfi_pkg::POS_W-1:0]  seg_lo_pos, seg_hi_pos;
   logic [tfi_pkg::DUTY_W-1:0]        seg_lo_duty, seg_hi_duty;
   logic                              div_start;
   logic [tfi_pkg::DUTY_W-1:0]        div_quot;
   tfi_pkg::div_status_type           div_status;

   // Halve the sum toward zero: add one to negative sums before the shift
   assign sum_adj = sum_ff + tfi_pkg::SUM_W'(sum_ff[tfi_pkg::SUM_W-1]);

   // Segment search: the lowest breakpoint above the average wins
   always_comb begin
      seg_lo_pos  = pos_ff[tfi_pkg::LAST_POINT-1];
      seg_hi_pos  = pos_ff[tfi_pkg::LAST_POINT];
      seg_lo_duty = duty_ff[tfi_pkg::LAST_POINT-1];
      seg_hi_duty = duty_ff[tfi_pkg::LAST_POINT];
      for (int k = tfi_pkg::LAST_POINT; k >= 1; k--) begin
         if (p_ff < pos_ff[k]) begin
            seg_lo_pos  = pos_ff[k-1];
            seg_hi_pos  = pos_ff[k];
            seg_lo_duty = duty_ff[k-1];
            seg_hi_duty = duty_ff[k];
         end
      end
   end

   // Segment slope terms; the divider sees magnitudes only
   assign dd     = $signed({1'b0, hi_duty_ff}) - $signed({1'b0, lo_duty_ff});
   assign dd_mag = dd[tfi_pkg::QUOT_W-1] ? tfi_pkg::DUTY_W'(-dd) : dd[tfi_pkg::DUTY_W-1:0];
   assign dp     = $signed({hi_pos_ff[tfi_pkg::POS_W-1], hi_pos_ff})
                 - $signed({lo_pos_ff[tfi_pkg::POS_W-1], lo_pos_ff});

   // Slope times offset; only the low 16 bits of the product survive the wrap
   assign prod_full = q_ff * dx_ff;

   always_comb begin
      state_in      = state_ff;
      sum_in        = sum_ff;
      p_in          = p_ff;
      lo_pos_in     = lo_pos_ff;
      hi_pos_in     = hi_pos_ff;
      lo_duty_in    = lo_duty_ff;
      hi_duty_in    = hi_duty_ff;
      dd_neg_in     = dd_neg_ff;
      dx_in         = dx_ff;
      q_in          = q_ff;
      prod_in       = prod_ff;
      rsp_strobe_in = 1'b0;
      rsp_duty_in   = rsp_duty_ff;
      div_start     = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               sum_in   = $signed({req_sensor_a_position[tfi_pkg::POS_W-1],
                                   req_sensor_a_position})
                        + $signed({req_sensor_b_position[tfi_pkg::POS_W-1],
                                   req_sensor_b_position});
               state_in = ST_AVG;
            end
         end
         ST_AVG: begin
            p_in     = sum_adj[tfi_pkg::SUM_W-1:1];
            state_in = ST_SEL;
         end
         ST_SEL: begin
            if (p_ff <= pos_ff[0]) begin
               // below the table: hold the first duty
               rsp_duty_in   = tfi_pkg::POS_W'(duty_ff[0]);
               rsp_strobe_in = 1'b1;
               state_in      = ST_IDLE;
            end else if (p_ff >= pos_ff[tfi_pkg::LAST_POINT]) begin
               // above the table: hold the last duty
               rsp_duty_in   = tfi_pkg::POS_W'(duty_ff[tfi_pkg::LAST_POINT]);
               rsp_strobe_in = 1'b1;
               state_in      = ST_IDLE;
            end else begin
               lo_pos_in  = seg_lo_pos;
               hi_pos_in  = seg_hi_pos;
               lo_duty_in = seg_lo_duty;
               hi_duty_in = seg_hi_duty;
               state_in   = ST_PREP;
            end
         end
         ST_PREP: begin
            dx_in     = $signed({p_ff[tfi_pkg::POS_W-1], p_ff})
                      - $signed({lo_pos_ff[tfi_pkg::POS_W-1], lo_pos_ff});
            dd_neg_in = dd[tfi_pkg::QUOT_W-1];
            if (dp <= 0) begin
               // flat or inverted segment: answer the lower duty
               rsp_duty_in   = tfi_pkg::POS_W'(lo_duty_ff);
               rsp_strobe_in = 1'b1;
               state_in      = ST_IDLE;
            end else begin
               div_start = 1'b1;
               state_in  = ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_status.done) begin
               // restore the slope sign; truncation toward zero falls out
               q_in     = dd_neg_ff ? -$signed({1'b0, div_quot}) : $signed({1'b0, div_quot});
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            prod_in  = prod_full[tfi_pkg::POS_W-1:0];
            state_in = ST_FIN;
         end
         ST_FIN: begin
            rsp_duty_in   = tfi_pkg::POS_W'(lo_duty_ff) + prod_ff;
            rsp_strobe_in = 1'b1;
            state_in      = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   tfi_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (dd_mag),
      .divisor  (dp[tfi_pkg::POS_W-1:0]),
      .quotient (div_quot),
      .status   (div_status)
   );

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      sum_ff      <= sum_in;
      p_ff        <= p_in;
      lo_pos_ff   <= lo_pos_in;
      hi_pos_ff   <= hi_pos_in;
      lo_duty_ff  <= lo_duty_in;
      hi_duty_ff  <= hi_duty_in;
      dd_neg_ff   <= dd_neg_in;
      dx_ff       <= dx_in;
      q_ff        <= q_in;
      prod_ff     <= prod_in;
      rsp_duty_ff <= rsp_duty_in;
   end

   // Spring table writes; position words first, duty words after them
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < tfi_pkg::NUM_SLOTS; i++) begin
            pos_ff[i]  <= tfi_pkg::POS_RESET[i];
            duty_ff[i] <= tfi_pkg::DUTY_RESET[i];
         end
      end else if (csr_write_enable) begin
         if (csr_index < tfi_pkg::REG_DUTY_BASE) begin
            pos_ff[csr_index[tfi_pkg::SLOT_W-1:0]] <=
               $signed(csr_write_data[tfi_pkg::POS_W-1:0]);
         end else begin
            duty_ff[csr_index[tfi_pkg::SLOT_W-1:0]] <=
               csr_write_data[tfi_pkg::DUTY_W-1:0];
         end
      end
   end

   assign busy                 = (state_ff != ST_IDLE);
   assign rsp_strobe           = rsp_strobe_ff;
   assign rsp_feedforward_duty = $signed(rsp_duty_ff);

   `TFI_ASSERT_NEXT(a_start_enters_avg, start && !busy, state_ff == ST_AVG,
      "accepted word did not enter the averaging step")
   `TFI_ASSERT_NEXT(a_fin_strobes, state_ff == ST_FIN, rsp_strobe_ff,
      "final step did not present a result")
   `TFI_ASSERT_SAME(a_strobe_idle, rsp_strobe_ff, state_ff == ST_IDLE,
      "result shown while the sequencer is still working")
   `TFI_ASSERT_SAME(a_div_in_div_state, div_status.busy || div_status.done,
      state_ff == ST_DIV, "divider running outside the divide step")

endmodule
